/* design/wsfl_pkg.sv */
// Package: sizes, codes, control-word types and the sequencer program of the slot pool.
`timescale 1ns / 1ps
package wsfl_pkg;

    // Pool geometry
    localparam int SLOTS       = 32;
    localparam int MAX_RESULTS = 32;
    localparam int LINK_W      = $clog2(SLOTS + 1);
    localparam int IDX_W       = $clog2(SLOTS);
    localparam int VALUE_W     = 32;

    typedef logic [LINK_W-1:0]  t_link;
    typedef logic [IDX_W-1:0]   t_idx;
    typedef logic [1:0]         t_kind;
    typedef logic [4:0]         t_num;
    typedef logic [VALUE_W-1:0] t_value;
    typedef logic [1:0]         t_status;

    localparam t_link NULL_LINK = t_link'(SLOTS);

    // Transaction kinds
    localparam t_kind KIND_ALLOC  = 2'd0;
    localparam t_kind KIND_DELETE = 2'd1;
    localparam t_kind KIND_LIST   = 2'd2;

    // Result status codes
    localparam t_status ST_OK        = 2'd0;
    localparam t_status ST_EXHAUSTED = 2'd1;
    localparam t_status ST_NOT_FOUND = 2'd2;
    localparam t_status ST_EMPTY     = 2'd3;

    // Datapath actions, one per microcode step
    typedef enum logic [3:0] {
        ACT_IDLE,
        ACT_ALLOC_RD,
        ACT_ALLOC_WR,
        ACT_EMIT_EXH,
        ACT_DEL_INIT,
        ACT_DEL_RD,
        ACT_DEL_ADV,
        ACT_DEL_UNLINK,
        ACT_DEL_FREE,
        ACT_EMIT_NF,
        ACT_LIST_INIT,
        ACT_LIST_RD,
        ACT_LIST_EMIT,
        ACT_EMIT_EMPTY
    } t_act;

    // Branch conditions
    typedef enum logic [2:0] {
        C_NONE,
        C_DISPATCH,
        C_FREE_NULL,
        C_WALK_END,
        C_MATCH,
        C_HEAD_NULL,
        C_LIST_LAST
    } t_cond;

    typedef logic [3:0] t_pc;

    // Step addresses
    localparam t_pc PC_IDLE = 4'd0;
    localparam t_pc PC_A0   = 4'd1;
    localparam t_pc PC_A1   = 4'd2;
    localparam t_pc PC_AEX  = 4'd3;
    localparam t_pc PC_D0   = 4'd4;
    localparam t_pc PC_D1   = 4'd5;
    localparam t_pc PC_D2   = 4'd6;
    localparam t_pc PC_DF1  = 4'd7;
    localparam t_pc PC_DF2  = 4'd8;
    localparam t_pc PC_DNF  = 4'd9;
    localparam t_pc PC_L0   = 4'd10;
    localparam t_pc PC_L1   = 4'd11;
    localparam t_pc PC_L2   = 4'd12;
    localparam t_pc PC_LE   = 4'd13;

    // Control word: action, branch condition, result flag, taken and fall-through targets
    typedef struct packed {
        t_act  act;
        t_cond cond;
        logic  emit;
        t_pc   tgt;
        t_pc   nxt;
    } t_uword;

    function automatic t_uword mk_uword(input t_act act, input t_cond cond,
                                        input logic emit, input t_pc tgt, input t_pc nxt);
        t_uword w;
        w.act  = act;
        w.cond = cond;
        w.emit = emit;
        w.tgt  = tgt;
        w.nxt  = nxt;
        return w;
    endfunction

    // Sequencer program store
    function automatic t_uword ucode(input t_pc pc);
        t_uword w;
        unique case (pc)
            PC_IDLE: w = mk_uword(ACT_IDLE,       C_DISPATCH,  1'b0, PC_IDLE, PC_IDLE);
            PC_A0:   w = mk_uword(ACT_ALLOC_RD,   C_FREE_NULL, 1'b0, PC_AEX,  PC_A1);
            PC_A1:   w = mk_uword(ACT_ALLOC_WR,   C_NONE,      1'b1, PC_IDLE, PC_IDLE);
            PC_AEX:  w = mk_uword(ACT_EMIT_EXH,   C_NONE,      1'b1, PC_IDLE, PC_IDLE);
            PC_D0:   w = mk_uword(ACT_DEL_INIT,   C_NONE,      1'b0, PC_D1,   PC_D1);
            PC_D1:   w = mk_uword(ACT_DEL_RD,     C_WALK_END,  1'b0, PC_DNF,  PC_D2);
            PC_D2:   w = mk_uword(ACT_DEL_ADV,    C_MATCH,     1'b0, PC_DF1,  PC_D1);
            PC_DF1:  w = mk_uword(ACT_DEL_UNLINK, C_NONE,      1'b0, PC_DF2,  PC_DF2);
            PC_DF2:  w = mk_uword(ACT_DEL_FREE,   C_NONE,      1'b1, PC_IDLE, PC_IDLE);
            PC_DNF:  w = mk_uword(ACT_EMIT_NF,    C_NONE,      1'b1, PC_IDLE, PC_IDLE);
            PC_L0:   w = mk_uword(ACT_LIST_INIT,  C_HEAD_NULL, 1'b0, PC_LE,   PC_L1);
            PC_L1:   w = mk_uword(ACT_LIST_RD,    C_NONE,      1'b0, PC_L2,   PC_L2);
            PC_L2:   w = mk_uword(ACT_LIST_EMIT,  C_LIST_LAST, 1'b1, PC_IDLE, PC_L1);
            PC_LE:   w = mk_uword(ACT_EMIT_EMPTY, C_NONE,      1'b1, PC_IDLE, PC_IDLE);
            default: w = mk_uword(ACT_IDLE,       C_NONE,      1'b0, PC_IDLE, PC_IDLE);
        endcase
        return w;
    endfunction

    // Any link outside the slot range terminates a walk
    function automatic logic is_null(input t_link l);
        return int'(l) >= SLOTS;
    endfunction

    // Low five bits of a link, zero-extended for small pools
    function automatic t_num slot_num(input t_link l);
        logic [LINK_W+4:0] w;
        w = {5'b0, l};
        return w[4:0];
    endfunction

    // Link equals a five-bit slot number, compared at common width
    function automatic logic link_is_num(input t_link l, input t_num n);
        logic [LINK_W+4:0] wl;
        logic [LINK_W+4:0] wn;
        wl = {5'b0, l};
        wn = {{LINK_W{1'b0}}, n};
        return wl == wn;
    endfunction

endpackage

/* design/wsfl_req_if.sv */
// Interface: request channel carrying one command transaction.
`timescale 1ns / 1ps
interface wsfl_req_if;
    import wsfl_pkg::*;

    logic   valid;
    logic   ready;
    t_kind  kind;
    t_num   watch_number;
    t_value initial_value;

    modport source (output valid, output kind, output watch_number, output initial_value,
                    input ready);
    modport sink   (input valid, input kind, input watch_number, input initial_value,
                    output ready);
endinterface

/* design/wsfl_rsp_if.sv */
// Interface: response channel carrying one result transaction.
`timescale 1ns / 1ps
interface wsfl_rsp_if;
    import wsfl_pkg::*;

    logic    valid;
    logic    ready;
    t_status status;
    t_num    slot_number;
    t_value  slot_value;
    logic    last;

    modport source (output valid, output status, output slot_number, output slot_value,
                    output last, input ready);
    modport sink   (input valid, input status, input slot_number, input slot_value,
                    input last, output ready);
endinterface

/* design/wsfl_ram.sv */
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps
module wsfl_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 32
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // Registered read port
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;
endmodule

/* design/watch_slot_free_list_pool_core.sv */
// Top level: microcoded slot pool with free and active linked lists.
//
//  channel  | dir | payload                                     | handshake
//  ---------+-----+---------------------------------------------+-------------
//  i_req    | in  | kind, watch_number, initial_value           | valid/ready
//  o_rsp    | out | status, slot_number, slot_value, last       | valid/ready
//
// One command at a time: request ready only in the idle step.
// Allocate: free-list link read, then slot write and result. Delete: link RAM read and advance per entry walked.
// List: one link/value read then one result per listed slot; a single empty result when empty.
// Reset clears pointers and per-slot valid bits at once; no clearing pass.
// A result step holds while the output register is full and not taken.
`timescale 1ns / 1ps
module watch_slot_free_list_pool_core (
    input  logic          i_clk,
    input  logic          i_rst_n,
    wsfl_req_if.sink      i_req,
    wsfl_rsp_if.source    o_rsp
);
    import wsfl_pkg::*;

    // Sequencer and datapath registers
    t_pc              r_pc, n_pc;
    t_link            r_active_head, n_active_head;
    t_link            r_free_head, n_free_head;
    t_link            r_cur, n_cur;
    t_link            r_prev, n_prev;
    t_link            r_steps, n_steps;
    t_num             r_num, n_num;
    t_value           r_init, n_init;
    logic [SLOTS-1:0] r_valid, n_valid;
    t_idx             r_rd_idx;
    logic             r_rd_vld;

    // Output register
    logic    r_out_valid, n_out_valid;
    t_status r_out_status, n_out_status;
    t_num    r_out_slot, n_out_slot;
    t_value  r_out_value, n_out_value;
    logic    r_out_last, n_out_last;

    // Memory ports
    logic   link_we, val_we, rd_en;
    t_idx   link_waddr, val_waddr, rd_addr;
    t_link  link_wdata, link_q, link_rd;
    t_value val_wdata, val_q, val_rd;

    t_uword uw;
    logic   req_fire, stall, taken, match, list_last, out_load;

    wsfl_ram #(.WIDTH(LINK_W), .DEPTH(SLOTS)) u_link_ram (
        .i_clk   (i_clk),
        .i_we    (link_we),
        .i_waddr (link_waddr),
        .i_wdata (link_wdata),
        .i_re    (rd_en),
        .i_raddr (rd_addr),
        .o_rdata (link_q)
    );

    wsfl_ram #(.WIDTH(VALUE_W), .DEPTH(SLOTS)) u_val_ram (
        .i_clk   (i_clk),
        .i_we    (val_we),
        .i_waddr (val_waddr),
        .i_wdata (val_wdata),
        .i_re    (rd_en),
        .i_raddr (rd_addr),
        .o_rdata (val_q)
    );

    // Never-allocated slots read as their reset contents
    assign link_rd = r_rd_vld ? link_q : t_link'(r_rd_idx) + t_link'(1);
    assign val_rd  = r_rd_vld ? val_q  : '0;

    assign uw        = ucode(r_pc);
    assign req_fire  = i_req.valid && i_req.ready;
    assign stall     = uw.emit && r_out_valid && !o_rsp.ready;
    assign match     = link_is_num(r_cur, r_num);
    assign list_last = is_null(link_rd) || (int'(r_steps) == SLOTS - 1)
                       || (int'(r_steps) == MAX_RESULTS - 1);

    assign i_req.ready = (r_pc == PC_IDLE);

    // Branch condition
    always_comb begin
        unique case (uw.cond)
            C_NONE:      taken = 1'b0;
            C_DISPATCH:  taken = 1'b0;
            C_FREE_NULL: taken = is_null(r_free_head);
            C_WALK_END:  taken = is_null(r_cur) || (int'(r_steps) == SLOTS);
            C_MATCH:     taken = match;
            C_HEAD_NULL: taken = is_null(r_active_head);
            C_LIST_LAST: taken = list_last;
            default:     taken = 1'b0;
        endcase
    end

    // Next step
    always_comb begin
        n_pc = r_pc;
        if (!stall) begin
            if (uw.cond == C_DISPATCH) begin
                if (req_fire) begin
                    case (i_req.kind)
                        KIND_ALLOC:  n_pc = PC_A0;
                        KIND_DELETE: n_pc = PC_D0;
                        KIND_LIST:   n_pc = PC_L0;
                        default:     n_pc = PC_IDLE;
                    endcase
                end
            end else begin
                n_pc = taken ? uw.tgt : uw.nxt;
            end
        end
    end

    // Datapath actions
    always_comb begin
        n_active_head = r_active_head;
        n_free_head   = r_free_head;
        n_cur         = r_cur;
        n_prev        = r_prev;
        n_steps       = r_steps;
        n_num         = r_num;
        n_init        = r_init;
        n_valid       = r_valid;
        link_we       = 1'b0;
        link_waddr    = r_cur[IDX_W-1:0];
        link_wdata    = r_free_head;
        val_we        = 1'b0;
        val_waddr     = r_cur[IDX_W-1:0];
        val_wdata     = '0;
        rd_en         = 1'b0;
        rd_addr       = r_cur[IDX_W-1:0];
        out_load      = 1'b0;
        n_out_status  = r_out_status;
        n_out_slot    = r_out_slot;
        n_out_value   = r_out_value;
        n_out_last    = r_out_last;

        if (!stall) begin
            unique case (uw.act)
                ACT_IDLE: begin
                    if (req_fire) begin
                        n_num  = i_req.watch_number;
                        n_init = i_req.initial_value;
                    end
                end
                ACT_ALLOC_RD: begin
                    rd_en   = !is_null(r_free_head);
                    rd_addr = r_free_head[IDX_W-1:0];
                end
                ACT_ALLOC_WR: begin
                    link_we    = 1'b1;
                    link_waddr = r_free_head[IDX_W-1:0];
                    link_wdata = r_active_head;
                    val_we     = 1'b1;
                    val_waddr  = r_free_head[IDX_W-1:0];
                    val_wdata  = r_init;
                    n_valid[r_free_head[IDX_W-1:0]] = 1'b1;
                    n_free_head   = link_rd;
                    n_active_head = r_free_head;
                    out_load      = 1'b1;
                    n_out_status  = ST_OK;
                    n_out_slot    = slot_num(r_free_head);
                    n_out_value   = r_init;
                    n_out_last    = 1'b1;
                end
                ACT_EMIT_EXH: begin
                    out_load     = 1'b1;
                    n_out_status = ST_EXHAUSTED;
                    n_out_slot   = '0;
                    n_out_value  = '0;
                    n_out_last   = 1'b1;
                end
                ACT_DEL_INIT: begin
                    n_cur   = r_active_head;
                    n_prev  = NULL_LINK;
                    n_steps = '0;
                end
                ACT_DEL_RD: begin
                    rd_en = !is_null(r_cur);
                end
                ACT_DEL_ADV: begin
                    if (!match) begin
                        n_prev  = r_cur;
                        n_cur   = link_rd;
                        n_steps = r_steps + t_link'(1);
                    end
                end
                ACT_DEL_UNLINK: begin
                    if (is_null(r_prev)) begin
                        n_active_head = link_rd;
                    end else begin
                        link_we    = 1'b1;
                        link_waddr = r_prev[IDX_W-1:0];
                        link_wdata = link_rd;
                    end
                end
                ACT_DEL_FREE: begin
                    link_we      = 1'b1;
                    link_wdata   = r_free_head;
                    val_we       = 1'b1;
                    val_wdata    = '0;
                    n_free_head  = r_cur;
                    out_load     = 1'b1;
                    n_out_status = ST_OK;
                    n_out_slot   = slot_num(r_cur);
                    n_out_value  = '0;
                    n_out_last   = 1'b1;
                end
                ACT_EMIT_NF: begin
                    out_load     = 1'b1;
                    n_out_status = ST_NOT_FOUND;
                    n_out_slot   = r_num;
                    n_out_value  = '0;
                    n_out_last   = 1'b1;
                end
                ACT_LIST_INIT: begin
                    n_cur   = r_active_head;
                    n_steps = '0;
                end
                ACT_LIST_RD: begin
                    rd_en = 1'b1;
                end
                ACT_LIST_EMIT: begin
                    out_load     = 1'b1;
                    n_out_status = ST_OK;
                    n_out_slot   = slot_num(r_cur);
                    n_out_value  = val_rd;
                    n_out_last   = list_last;
                    n_cur        = link_rd;
                    n_steps      = r_steps + t_link'(1);
                end
                ACT_EMIT_EMPTY: begin
                    out_load     = 1'b1;
                    n_out_status = ST_EMPTY;
                    n_out_slot   = '0;
                    n_out_value  = '0;
                    n_out_last   = 1'b1;
                end
                default: begin
                end
            endcase
        end
    end

    // Output valid: cleared when taken, set on a new result
    always_comb begin
        n_out_valid = r_out_valid && !o_rsp.ready;
        if (out_load) begin
            n_out_valid = 1'b1;
        end
    end

    // Control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pc          <= PC_IDLE;
            r_active_head <= NULL_LINK;
            r_free_head   <= '0;
            r_valid       <= '0;
            r_out_valid   <= 1'b0;
        end else begin
            r_pc          <= n_pc;
            r_active_head <= n_active_head;
            r_free_head   <= n_free_head;
            r_valid       <= n_valid;
            r_out_valid   <= n_out_valid;
        end
    end

    // Payload and walk registers
    always_ff @(posedge i_clk) begin
        r_cur        <= n_cur;
        r_prev       <= n_prev;
        r_steps      <= n_steps;
        r_num        <= n_num;
        r_init       <= n_init;
        r_out_status <= n_out_status;
        r_out_slot   <= n_out_slot;
        r_out_value  <= n_out_value;
        r_out_last   <= n_out_last;
        if (rd_en) begin
            r_rd_idx <= rd_addr;
            r_rd_vld <= r_valid[rd_addr];
        end
    end

    assign o_rsp.valid       = r_out_valid;
    assign o_rsp.status      = r_out_status;
    assign o_rsp.slot_number = r_out_slot;
    assign o_rsp.slot_value  = r_out_value;
    assign o_rsp.last        = r_out_last;
endmodule

/* bench/testbench.sv */
// Testbench for the slot pool: directed table, then random sequences checked against a predictor.
`timescale 1ns / 1ps
module testbench;
    import wsfl_pkg::*;

    // Kind code the block ignores
    localparam t_kind KIND_UNUSED = 2'd3;
    localparam int    STALL_LIMIT = 2000;
    localparam int    RANDOM_ITEMS = 310;
    localparam int    IDLE_PCT = 27;

    typedef struct packed {
        t_status status;
        t_num    slot_number;
        t_value  slot_value;
        logic    last;
    } t_pool_result;

    typedef struct packed {
        t_kind        kind;
        t_num         num;
        t_value       value;
        logic         fixed;
        t_pool_result res;
    } t_plan_row;

    // Directed table; rows with fixed set carry a typed-in result
    localparam t_plan_row DIRECTED [17] = '{
        '{KIND_LIST,   5'd0,  32'h0,        1'b1, '{ST_EMPTY,     5'd0,  32'h0,        1'b1}},
        '{KIND_DELETE, 5'd0,  32'h0,        1'b1, '{ST_NOT_FOUND, 5'd0,  32'h0,        1'b1}},
        '{KIND_DELETE, 5'd31, 32'hFFFFFFFF, 1'b1, '{ST_NOT_FOUND, 5'd31, 32'h0,        1'b1}},
        '{KIND_UNUSED, 5'd31, 32'hFFFFFFFF, 1'b0, '{ST_OK,        5'd0,  32'h0,        1'b0}},
        '{KIND_ALLOC,  5'd31, 32'h0,        1'b1, '{ST_OK,        5'd0,  32'h0,        1'b1}},
        '{KIND_ALLOC,  5'd0,  32'hFFFFFFFF, 1'b1, '{ST_OK,        5'd1,  32'hFFFFFFFF, 1'b1}},
        '{KIND_ALLOC,  5'd0,  32'hA5A5A5A5, 1'b1, '{ST_OK,        5'd2,  32'hA5A5A5A5, 1'b1}},
        '{KIND_LIST,   5'd0,  32'h0,        1'b0, '{ST_OK,        5'd0,  32'h0,        1'b0}},
        '{KIND_DELETE, 5'd1,  32'h0,        1'b1, '{ST_OK,        5'd1,  32'h0,        1'b1}},
        '{KIND_DELETE, 5'd2,  32'h0,        1'b1, '{ST_OK,        5'd2,  32'h0,        1'b1}},
        '{KIND_DELETE, 5'd31, 32'h0,        1'b1, '{ST_NOT_FOUND, 5'd31, 32'h0,        1'b1}},
        '{KIND_DELETE, 5'd0,  32'h0,        1'b1, '{ST_OK,        5'd0,  32'h0,        1'b1}},
        '{KIND_DELETE, 5'd0,  32'h0,        1'b1, '{ST_NOT_FOUND, 5'd0,  32'h0,        1'b1}},
        '{KIND_LIST,   5'd0,  32'h0,        1'b1, '{ST_EMPTY,     5'd0,  32'h0,        1'b1}},
        '{KIND_ALLOC,  5'd0,  32'h5A5A5A5A, 1'b0, '{ST_OK,        5'd0,  32'h0,        1'b0}},
        '{KIND_ALLOC,  5'd0,  32'h00000001, 1'b0, '{ST_OK,        5'd0,  32'h0,        1'b0}},
        '{KIND_LIST,   5'd0,  32'h0,        1'b0, '{ST_OK,        5'd0,  32'h0,        1'b0}}
    };

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;

    wsfl_req_if req_ch ();
    wsfl_rsp_if rsp_ch ();

    watch_slot_free_list_pool_core dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req_ch),
        .o_rsp   (rsp_ch)
    );

    // Predicted pool state
    t_link  link_mem [SLOTS];
    t_value val_mem  [SLOTS];
    t_link  act_head;
    t_link  free_head;
    int     n_active;

    // Results of items presented but not yet accepted, and of accepted items
    t_pool_result queued_item_results [$];
    int           queued_item_counts  [$];
    t_pool_result pending_results     [$];

    int n_errors = 0;
    int n_sent = 0;
    int idle_cycles = 0;
    bit no_idle = 1'b0;

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    function automatic void stage_result(input t_status st, input t_num sn,
                                         input t_value sv, input logic lst);
        t_pool_result r;
        r.status      = st;
        r.slot_number = sn;
        r.slot_value  = sv;
        r.last        = lst;
        queued_item_results.push_back(r);
    endfunction

    // Apply one item to the predicted pool, stage its results, return how many
    function automatic int pool_apply(input t_kind k, input t_num num, input t_value init);
        t_link        cur;
        t_link        prv;
        int           steps;
        int           n;
        t_pool_result tail;
        case (k)
            KIND_ALLOC: begin
                cur = free_head;
                if (int'(cur) >= SLOTS) begin
                    stage_result(ST_EXHAUSTED, 5'd0, 32'd0, 1'b1);
                    return 1;
                end
                free_head     = link_mem[cur];
                link_mem[cur] = act_head;
                act_head      = cur;
                val_mem[cur]  = init;
                n_active++;
                stage_result(ST_OK, cur[4:0], init, 1'b1);
                return 1;
            end
            KIND_DELETE: begin
                prv   = NULL_LINK;
                cur   = act_head;
                steps = 0;
                while (int'(cur) < SLOTS && cur != t_link'(num) && steps < SLOTS) begin
                    prv = cur;
                    cur = link_mem[cur];
                    steps++;
                end
                if (int'(cur) >= SLOTS || cur != t_link'(num)) begin
                    stage_result(ST_NOT_FOUND, num, 32'd0, 1'b1);
                    return 1;
                end
                if (int'(prv) >= SLOTS) begin
                    act_head = link_mem[cur];
                end else begin
                    link_mem[prv] = link_mem[cur];
                end
                val_mem[cur]  = '0;
                link_mem[cur] = free_head;
                free_head     = cur;
                n_active--;
                stage_result(ST_OK, cur[4:0], 32'd0, 1'b1);
                return 1;
            end
            KIND_LIST: begin
                cur = act_head;
                if (int'(cur) >= SLOTS) begin
                    stage_result(ST_EMPTY, 5'd0, 32'd0, 1'b1);
                    return 1;
                end
                n     = 0;
                steps = 0;
                while (int'(cur) < SLOTS && n < MAX_RESULTS && steps < SLOTS) begin
                    stage_result(ST_OK, cur[4:0], val_mem[cur], 1'b0);
                    n++;
                    steps++;
                    cur = link_mem[cur];
                end
                tail      = queued_item_results.pop_back();
                tail.last = 1'b1;
                queued_item_results.push_back(tail);
                return n;
            end
            default: return 0;
        endcase
    endfunction

    // Random slot from the predicted active list
    function automatic t_num pick_active();
        t_link cur;
        t_num  found [$];
        int    steps;
        cur   = act_head;
        steps = 0;
        while (int'(cur) < SLOTS && steps < SLOTS) begin
            found.push_back(cur[4:0]);
            cur = link_mem[cur];
            steps++;
        end
        if (found.size() == 0) return t_num'($urandom());
        return found[$urandom_range(0, found.size() - 1)];
    endfunction

    function automatic t_value any_value();
        case ($urandom_range(0, 7))
            0: return '0;
            1: return '1;
            default: return t_value'($urandom());
        endcase
    endfunction

    // Present one transaction and wait until it is taken
    task automatic send_item(input t_kind k, input t_num num, input t_value v,
                             input logic fixed, input t_pool_result fx);
        int c;
        c = pool_apply(k, num, v);
        if (fixed) begin
            repeat (c) void'(queued_item_results.pop_back());
            queued_item_results.push_back(fx);
            c = 1;
        end
        queued_item_counts.push_back(c);
        if (!no_idle && $urandom_range(0, 99) < IDLE_PCT) begin
            req_ch.valid         <= 1'b0;
            req_ch.kind          <= t_kind'($urandom());
            req_ch.watch_number  <= t_num'($urandom());
            req_ch.initial_value <= t_value'($urandom());
            repeat ($urandom_range(1, 4)) @(posedge i_clk);
        end
        req_ch.valid         <= 1'b1;
        req_ch.kind          <= k;
        req_ch.watch_number  <= num;
        req_ch.initial_value <= v;
        n_sent++;
        do @(posedge i_clk); while (!req_ch.ready);
    endtask

    // Result sink: random back-pressure outside the calm stretch
    always @(posedge i_clk) begin
        rsp_ch.ready <= no_idle || ($urandom_range(0, 99) >= IDLE_PCT);
    end

    // Checker: match accepted results in order, release expectations on request acceptance
    always @(posedge i_clk) begin : result_check
        t_pool_result want;
        int           cnt;
        if (i_rst_n) begin
            if (rsp_ch.valid && rsp_ch.ready) begin
                if (pending_results.size() == 0) begin
                    $error("result with nothing expected: status %0d slot %0d value %h",
                           rsp_ch.status, rsp_ch.slot_number, rsp_ch.slot_value);
                    n_errors++;
                end else begin
                    want = pending_results.pop_front();
                    if (rsp_ch.status !== want.status) begin
                        $error("status: expected %0d, got %0d", want.status, rsp_ch.status);
                        n_errors++;
                    end
                    if (rsp_ch.slot_number !== want.slot_number) begin
                        $error("slot_number: expected %0d, got %0d",
                               want.slot_number, rsp_ch.slot_number);
                        n_errors++;
                    end
                    if (rsp_ch.slot_value !== want.slot_value) begin
                        $error("slot_value: expected %h, got %h",
                               want.slot_value, rsp_ch.slot_value);
                        n_errors++;
                    end
                    if (rsp_ch.last !== want.last) begin
                        $error("last: expected %0d, got %0d", want.last, rsp_ch.last);
                        n_errors++;
                    end
                end
            end
            if (req_ch.valid && req_ch.ready) begin
                if (queued_item_counts.size() == 0) begin
                    $error("request taken with none presented");
                    n_errors++;
                end else begin
                    cnt = queued_item_counts.pop_front();
                    repeat (cnt) pending_results.push_back(queued_item_results.pop_front());
                end
            end
            if ((rsp_ch.valid && rsp_ch.ready) || (req_ch.valid && req_ch.ready)) begin
                idle_cycles <= 0;
            end else begin
                idle_cycles <= idle_cycles + 1;
            end
        end
    end

    // Watchdog on cycles without any transaction
    initial begin
        while (idle_cycles < STALL_LIMIT) @(posedge i_clk);
        $display("simulation failed");
        $finish;
    end

    // Stimulus and verdict
    initial begin : stimulus
        int           sel;
        int           cnt;
        t_pool_result none;
        none = '0;
        req_ch.valid         <= 1'b0;
        req_ch.kind          <= KIND_ALLOC;
        req_ch.watch_number  <= '0;
        req_ch.initial_value <= '0;
        for (int i = 0; i < SLOTS; i++) begin
            link_mem[i] = t_link'(i + 1);
            val_mem[i]  = '0;
        end
        act_head  = NULL_LINK;
        free_head = '0;
        n_active  = 0;

        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed table
        foreach (DIRECTED[i]) begin
            send_item(DIRECTED[i].kind, DIRECTED[i].num, DIRECTED[i].value,
                      DIRECTED[i].fixed, DIRECTED[i].res);
        end

        // Random sequences: fill to exhaustion, drain, or mixed single items
        n_sent = 0;
        while (n_sent < RANDOM_ITEMS) begin
            no_idle = (n_sent >= 120 && n_sent < 190);
            sel = $urandom_range(0, 99);
            if (sel < 20) begin
                cnt = SLOTS - n_active + $urandom_range(1, 2);
                repeat (cnt) send_item(KIND_ALLOC, t_num'($urandom()), any_value(), 1'b0, none);
                send_item(KIND_LIST, t_num'($urandom()), any_value(), 1'b0, none);
            end else if (sel < 35) begin
                cnt = $urandom_range(1, n_active + 1);
                repeat (cnt) begin
                    if (n_active > 0 && $urandom_range(0, 99) < 85) begin
                        send_item(KIND_DELETE, pick_active(), any_value(), 1'b0, none);
                    end else begin
                        send_item(KIND_DELETE, t_num'($urandom()), any_value(), 1'b0, none);
                    end
                end
                send_item(KIND_LIST, t_num'($urandom()), any_value(), 1'b0, none);
            end else begin
                sel = $urandom_range(0, 99);
                if (sel < 48) begin
                    send_item(KIND_ALLOC, t_num'($urandom()), any_value(), 1'b0, none);
                end else if (sel < 65) begin
                    send_item(KIND_DELETE, pick_active(), any_value(), 1'b0, none);
                end else if (sel < 78) begin
                    send_item(KIND_DELETE, t_num'($urandom()), any_value(), 1'b0, none);
                end else if (sel < 94) begin
                    send_item(KIND_LIST, t_num'($urandom()), any_value(), 1'b0, none);
                end else begin
                    send_item(KIND_UNUSED, t_num'($urandom()), any_value(), 1'b0, none);
                end
            end
        end
        no_idle = 1'b0;
        req_ch.valid <= 1'b0;

        // Drain outstanding results, then allow for stragglers
        while (pending_results.size() != 0 || queued_item_counts.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (80) @(posedge i_clk);

        if (n_errors == 0 && pending_results.size() == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule
